FILE: hw/rtl/dfatw_pkg.sv
package dfatw_pkg;

  localparam int LANE_FIELDS  = 8;
  localparam int SYM_COUNT_W  = 9;
  localparam int OPCODE_W     = 2;
  localparam int INDEX_W      = 16;
  localparam int VALUE_W      = 8;
  localparam int SYMBOL_W     = 8;
  localparam int LANE_OUT_W   = 8;

  localparam int OPCODE_LSB   = 0;
  localparam int INDEX_LSB    = OPCODE_LSB + OPCODE_W;
  localparam int VALUE_LSB    = INDEX_LSB + INDEX_W;
  localparam int SYMBOL_LSB   = VALUE_LSB + VALUE_W;
  localparam int IN_FIELDS_W  = SYMBOL_LSB + LANE_FIELDS * SYMBOL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = LANE_FIELDS * LANE_OUT_W;

  localparam logic [SYM_COUNT_W-1:0] SYM_COUNT_RESET = 9'd256;

  localparam logic [OPCODE_W-1:0] OP_TABLE_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LANE_LOAD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_STEP        = 2'd2;

  typedef struct packed {
    logic step;
    logic load;
    logic tbl_wr;
  } lane_ctl_t;

endpackage

FILE: hw/rtl/parallel_dfa_table_walker_core.sv
// channel  | handshake                      | payload
// s_axis   | s_axis_tvalid / s_axis_tready  | tdata: opcode, table_index, entry_value,
//          |                                |   lane0..7 symbol; tlast: final_step
// m_axis   | m_axis_tvalid / m_axis_tready  | tdata: lane0..7 state; tuser: range_error;
//          |                                |   tlast: chunk_done
// cfg      | cfg_valid / cfg_ready          | cfg_data: symbol_count
//
// One request per cycle while no result is held; result appears the cycle after acceptance.
// Per lane: lane state -> multiply/add address -> table read.
// Each lane reads its own copy of the table; table writes go to all copies.
// rst is synchronous: lane states 0, symbol_count 256, table contents undefined.
// A held result stalls s_axis; a request is accepted in the cycle it is taken out.
module parallel_dfa_table_walker_core
  import dfatw_pkg::*;
#(
  parameter int LANES       = 8,
  parameter int TABLE_DEPTH = 65536,
  parameter int STATE_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] opcode, [17:2] table_index, [25:18] entry_value,
  // [33:26]..[89:82] lane0..lane7 symbol, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0]..[63:56] lane0..lane7 state
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] range_error
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SYM_COUNT_W-1:0] cfg_data
);

  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int WR_W   = (TBL_AW + 1 > INDEX_W + 1) ? TBL_AW + 1 : INDEX_W + 1;

  logic [SYM_COUNT_W-1:0] sym_count;
  logic                   accept;
  logic [OPCODE_W-1:0]    opcode;
  logic [INDEX_W-1:0]     table_index;
  logic [STATE_BITS-1:0]  value;
  logic [WR_W-1:0]        index_ext;
  logic                   wr_in_range;
  logic                   is_step;
  logic                   res_valid;
  logic                   res_err;
  logic                   res_done;
  logic                   err_next;
  logic [LANES-1:0]       lane_err;
  logic [STATE_BITS-1:0]  lane_state [LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_count <= SYM_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sym_count <= cfg_data;
    end
  end

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign opcode        = s_axis_tdata[OPCODE_LSB +: OPCODE_W];
  assign table_index   = s_axis_tdata[INDEX_LSB +: INDEX_W];
  assign value         = STATE_BITS'(s_axis_tdata[VALUE_LSB +: VALUE_W]);
  assign index_ext     = WR_W'(table_index);
  assign wr_in_range   = index_ext < WR_W'(TABLE_DEPTH);
  assign is_step       = opcode == OP_STEP;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lane_ctl_t           ctl;
    logic [SYMBOL_W-1:0] sym;

    if (l < LANE_FIELDS) begin : g_sym
      assign sym = s_axis_tdata[SYMBOL_LSB + l * SYMBOL_W +: SYMBOL_W];
    end else begin : g_nosym
      assign sym = '0;
    end

    assign ctl.step   = accept && is_step;
    assign ctl.load   = accept && opcode == OP_LANE_LOAD && table_index == INDEX_W'(l);
    assign ctl.tbl_wr = accept && opcode == OP_TABLE_WRITE && wr_in_range;

    dfatw_lane #(
      .STATE_BITS  (STATE_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .symbol     (sym),
      .sym_count  (sym_count),
      .load_value (value),
      .wr_addr    (index_ext[TBL_AW-1:0]),
      .wr_data    (value),
      .state      (lane_state[l]),
      .step_err   (lane_err[l])
    );
  end

  always_comb begin
    case (opcode)
      OP_TABLE_WRITE: err_next = !wr_in_range;
      OP_STEP:        err_next = |lane_err;
      default:        err_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_err  <= err_next;
      res_done <= is_step && s_axis_tlast;
    end
  end

  for (genvar l = 0; l < LANE_FIELDS; l++) begin : g_out
    if (l < LANES) begin : g_used
      assign m_axis_tdata[l * LANE_OUT_W +: LANE_OUT_W] = LANE_OUT_W'(lane_state[l]);
    end else begin : g_unused
      assign m_axis_tdata[l * LANE_OUT_W +: LANE_OUT_W] = '0;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_err;
  assign m_axis_tlast  = res_done;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted request gave no result");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request accepted over a held result");

  a_done_only_step: assert property (@(posedge clk) disable iff (rst)
    accept && !is_step |=> !m_axis_tlast)
    else $error("chunk_done set on a non-step request");

endmodule

FILE: hw/rtl/dfatw_table_ram.sv
module dfatw_table_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/dfatw_lane.sv
module dfatw_lane
  import dfatw_pkg::*;
#(
  parameter int STATE_BITS  = 8,
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lane_ctl_t                       ctl,
  input  logic [SYMBOL_W-1:0]             symbol,
  input  logic [SYM_COUNT_W-1:0]          sym_count,
  input  logic [STATE_BITS-1:0]           load_value,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  wr_addr,
  input  logic [STATE_BITS-1:0]           wr_data,
  output logic [STATE_BITS-1:0]           state,
  output logic                            step_err
);

  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int PROD_W = STATE_BITS + SYM_COUNT_W + 1;
  localparam int SUM_W  = (PROD_W > TBL_AW + 1) ? PROD_W : TBL_AW + 1;

  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_TABLE,
    SEL_LOAD
  } sel_t;

  sel_t                  sel;
  logic [STATE_BITS-1:0] state_reg;
  logic [STATE_BITS-1:0] load_reg;
  logic [STATE_BITS-1:0] rd_data;
  logic [SUM_W-1:0]      addr_full;
  logic                  rd_en;

  // current state, with the previous request's table read or lane load forwarded
  always_comb begin
    unique case (sel)
      SEL_TABLE: state = rd_data;
      SEL_LOAD:  state = load_reg;
      default:   state = state_reg;
    endcase
  end

  assign addr_full = SUM_W'(state) * SUM_W'(sym_count) + SUM_W'(symbol);
  assign step_err  = addr_full >= SUM_W'(TABLE_DEPTH);
  assign rd_en     = ctl.step && !step_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= SEL_KEEP;
      state_reg <= '0;
    end else begin
      state_reg <= state;
      if (rd_en) begin
        sel <= SEL_TABLE;
      end else if (ctl.load) begin
        sel <= SEL_LOAD;
      end else begin
        sel <= SEL_KEEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      load_reg <= load_value;
    end
  end

  dfatw_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (TBL_AW),
    .DW    (STATE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.tbl_wr),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (addr_full[TBL_AW-1:0]),
    .rdata (rd_data)
  );

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> !ctl.load && !ctl.tbl_wr)
    else $error("lane got more than one operation");

  a_load_seen: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> state == $past(load_value))
    else $error("lane load not visible next cycle");

  a_err_keeps: assert property (@(posedge clk) disable iff (rst)
    ctl.step && step_err |=> state == $past(state))
    else $error("out-of-range step changed lane state");

endmodule
